/* rtl/core/assert_macros.svh */
// assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/sgsc_pkg.sv */
// shared types, constants and ratio table of the gear shift controller
package sgsc_pkg;

	// field widths
	localparam int SPD_W      = 14;
	localparam int TICKS_W    = 8;
	localparam int RED_W      = 14;
	localparam int GEAR_W     = 3;
	localparam int STATUS_W   = 3;
	localparam int RATIO_W    = 15;
	localparam int FRAC_W     = 16;
	localparam int PROD_W     = SPD_W + FRAC_W;
	localparam int IN_W       = 48;
	localparam int OUT_W      = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	// input word bit positions
	localparam int IN_WHEEL_LSB  = 0;
	localparam int IN_UP_BIT     = 14;
	localparam int IN_DOWN_BIT   = 15;
	localparam int IN_CLUTCH_BIT = 16;
	localparam int IN_MOTOR_LSB  = 17;
	localparam int IN_ENGINE_LSB = 31;

	// gear codes
	localparam logic [GEAR_W-1:0] GEAR_NEUTRAL  = 3'd0;
	localparam logic [GEAR_W-1:0] GEAR_FIRST    = 3'd1;
	localparam logic [GEAR_W-1:0] GEAR_SECOND   = 3'd2;
	localparam logic [GEAR_W-1:0] GEAR_TOP      = 3'd5;
	localparam logic [GEAR_W-1:0] GEAR_SHIFTING = 3'd6;

	// band half width 0.01 in q0.16, redline cap
	localparam logic [RATIO_W-1:0] BAND_Q16    = 15'd655;
	localparam logic [RED_W-1:0]   REDLINE_CAP = 14'd14000;

	// register reset values
	localparam logic [TICKS_W-1:0] HOLD_TICKS_RST = 8'd3;
	localparam logic [RED_W-1:0]   REDLINE_RST    = 14'd12000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REDLINE    = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		SS_IDLE    = 3'd0,
		SS_START   = 3'd1,
		SS_BOTH    = 3'd2,
		SS_REFUSED = 3'd3,
		SS_DONE    = 3'd4
	} shift_status_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic meas_step;
		logic red_eval;
		logic commit;
	} sgsc_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic meas_done;
	} sgsc_stat_t;

	// overall ratio per gear in q0.16, zero for codes without a gear
	function automatic logic [RATIO_W-1:0] ratio_q16(input logic [GEAR_W-1:0] gear);
		logic [RATIO_W-1:0] r;
		case (gear)
			3'd1:    r = 15'd8753;
			3'd2:    r = 15'd10773;
			3'd3:    r = 15'd13082;
			3'd4:    r = 15'd15745;
			3'd5:    r = 15'd18099;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/sgsc_datapath.sv */
// datapath: input capture, gear band search, redline check and shift state
module sgsc_datapath
	import sgsc_pkg::*;
#(
	parameter int HOLD_COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [IN_W-1:0]       in_word,
	input  sgsc_cmd_t             cmd,
	output sgsc_stat_t            stat,
	output logic [OUT_W-1:0]      out_word
);

	localparam logic [HOLD_COUNT_BITS-1:0] HOLD_MAX = '1;
	localparam int CMP_W = (HOLD_COUNT_BITS > TICKS_W) ? HOLD_COUNT_BITS : TICKS_W;

	// configuration registers
	logic [TICKS_W-1:0] hold_ticks_q;
	logic [RED_W-1:0]   redline_q;

	// captured input word
	logic [SPD_W-1:0] wheel_q, motor_q, engine_q;
	logic             up_q, down_q, clutch_q;

	// persistent shift state
	logic [GEAR_W-1:0]          cur_gear_q, target_q;
	logic [HOLD_COUNT_BITS-1:0] hold_q;
	logic                       sol_up_q, sol_dn_q;

	// per-word working registers
	logic [GEAR_W-1:0] work_q, idx_q;
	logic              red_ok_q;
	logic [OUT_W-1:0]  out_q;

	// band search terms
	logic              meas_need;
	logic [RATIO_W-1:0] ratio_c;
	logic [PROD_W-1:0] lhs_c, hi_c, lo_c;
	logic              match_c;

	// redline terms
	logic [GEAR_W-1:0] red_tgt_c;
	logic [RED_W-1:0]  red_cap_c;
	logic [PROD_W-1:0] red_prod_c, wheel_sh_c;
	logic              red_ok_c;

	// next shift state
	logic [GEAR_W-1:0]          gear_n, target_n;
	logic [HOLD_COUNT_BITS-1:0] hold_n, hold_inc;
	logic                       sol_up_n, sol_dn_n;
	shift_status_t              status_n;
	logic                       up_ok;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_TICKS_RST;
			redline_q    <= REDLINE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_HOLD_TICKS: hold_ticks_q <= cfg_data[TICKS_W-1:0];
				CFG_REDLINE:    redline_q    <= cfg_data[RED_W-1:0];
				default:        ;
			endcase
		end
	end

	// one gear band per cycle, both band edges compared
	assign meas_need = clutch_q && (cur_gear_q != GEAR_SHIFTING);
	assign ratio_c   = ratio_q16(idx_q);
	assign lhs_c     = {motor_q, {FRAC_W{1'b0}}};
	assign hi_c      = PROD_W'(ratio_c + BAND_Q16) * PROD_W'(engine_q);
	assign lo_c      = PROD_W'(ratio_c - BAND_Q16) * PROD_W'(engine_q);
	assign match_c   = (lhs_c <= hi_c) && (lhs_c >= lo_c);

	assign stat.meas_done = !meas_need || (engine_q == '0) || match_c || (idx_q == GEAR_TOP);

	// target gear of the requested shift and its redline product
	always_comb begin
		if (down_q) begin
			red_tgt_c = (work_q == GEAR_NEUTRAL) ? GEAR_FIRST : work_q - GEAR_W'(1);
		end else begin
			red_tgt_c = work_q + GEAR_W'(1);
		end
		red_cap_c  = (redline_q > REDLINE_CAP) ? REDLINE_CAP : redline_q;
		red_prod_c = PROD_W'(red_cap_c) * PROD_W'(ratio_q16(red_tgt_c));
		wheel_sh_c = {wheel_q, {FRAC_W{1'b0}}};
		red_ok_c   = (red_tgt_c >= GEAR_FIRST) && (red_tgt_c <= GEAR_TOP) &&
			(wheel_sh_c < red_prod_c);
	end

	// shift decision for the word in hand
	always_comb begin
		gear_n   = work_q;
		target_n = target_q;
		hold_n   = hold_q;
		sol_up_n = sol_up_q;
		sol_dn_n = sol_dn_q;
		status_n = SS_IDLE;
		hold_inc = (hold_q < HOLD_MAX) ? hold_q + HOLD_COUNT_BITS'(1) : hold_q;
		up_ok    = (work_q != GEAR_TOP) && clutch_q &&
			((work_q == GEAR_NEUTRAL) || red_ok_q);
		if (work_q == GEAR_SHIFTING) begin
			hold_n = hold_inc;
			if (CMP_W'(hold_inc) >= CMP_W'(hold_ticks_q)) begin
				sol_up_n = 1'b0;
				sol_dn_n = 1'b0;
				gear_n   = target_q;
				status_n = SS_DONE;
			end
		end else if (work_q <= GEAR_TOP) begin
			if (up_q && down_q) begin
				status_n = SS_BOTH;
			end else if (down_q) begin
				if ((work_q != GEAR_FIRST) && clutch_q && red_ok_q) begin
					hold_n   = '0;
					sol_dn_n = 1'b1;
					target_n = (work_q == GEAR_NEUTRAL) ? GEAR_FIRST : work_q - GEAR_W'(1);
					gear_n   = GEAR_SHIFTING;
					status_n = SS_START;
				end else begin
					status_n = SS_REFUSED;
				end
			end else if (up_q) begin
				if (up_ok) begin
					hold_n   = '0;
					sol_up_n = 1'b1;
					target_n = (work_q == GEAR_NEUTRAL) ? GEAR_SECOND : work_q + GEAR_W'(1);
					gear_n   = GEAR_SHIFTING;
					status_n = SS_START;
				end else begin
					status_n = SS_REFUSED;
				end
			end
		end
	end

	// word capture, band search steps, redline flag and result word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wheel_q  <= in_word[IN_WHEEL_LSB +: SPD_W];
			up_q     <= in_word[IN_UP_BIT];
			down_q   <= in_word[IN_DOWN_BIT];
			clutch_q <= in_word[IN_CLUTCH_BIT];
			motor_q  <= in_word[IN_MOTOR_LSB +: SPD_W];
			engine_q <= in_word[IN_ENGINE_LSB +: SPD_W];
			work_q   <= cur_gear_q;
			idx_q    <= GEAR_FIRST;
		end else if (cmd.meas_step && meas_need) begin
			if (engine_q == '0) begin
				work_q <= GEAR_SHIFTING;
			end else if (match_c) begin
				work_q <= idx_q;
			end else if (idx_q == GEAR_TOP) begin
				work_q <= GEAR_SHIFTING;
			end else begin
				idx_q <= idx_q + GEAR_W'(1);
			end
		end
		if (cmd.red_eval) begin
			red_ok_q <= red_ok_c;
		end
		if (cmd.commit) begin
			out_q <= {status_n, sol_dn_n, sol_up_n, gear_n};
		end
	end

	// persistent state, updated once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_gear_q <= GEAR_NEUTRAL;
			target_q   <= GEAR_NEUTRAL;
			hold_q     <= '0;
			sol_up_q   <= 1'b0;
			sol_dn_q   <= 1'b0;
		end else if (cmd.commit) begin
			cur_gear_q <= gear_n;
			target_q   <= target_n;
			hold_q     <= hold_n;
			sol_up_q   <= sol_up_n;
			sol_dn_q   <= sol_dn_n;
		end
	end

	assign out_word = out_q;

endmodule

/* rtl/core/sgsc_ctrl.sv */
// controller: sequences capture, band search, redline check and result hand-off
module sgsc_ctrl
	import sgsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  sgsc_stat_t stat,
	output sgsc_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MEAS = 4'b0010,
		S_RED  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_n       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_MEAS;
				end
			end
			S_MEAS: begin
				cmd.meas_step = 1'b1;
				if (stat.meas_done) begin
					state_n = S_RED;
				end
			end
			S_RED: begin
				cmd.red_eval = 1'b1;
				state_n      = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_n    = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// state register and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* rtl/core/sequential_gear_shift_controller_core.sv */
// top level of the sequential gear shift controller
// Usage:
//   s_axis: one word per control tick (wheel, motor and engine speed, the up,
//   down and clutch buttons). m_axis: one result word per input word with the
//   gear after the tick, both solenoid drives and the shift status.
//   cfg: write channel for shift_hold_ticks (index 0) and redline_rpm
//   (index 1); cfg_ready is always high, write only while no word is in work.
// Sequence:
//   an accepted word is captured, then goes through the gear band search (one
//   gear per cycle through the shared pair of band multipliers, ending at the
//   first match or at top gear, at once with the clutch up, the engine stopped
//   or a shift in progress), the redline multiply and the commit step, which
//   waits for a free output slot. The core works on one word at a time.
//   s_tready is high only while the controller waits for a word, so the next
//   word can enter while the previous result still sits in the output register.
// Reset: arst_n clears gear, target, hold count and solenoids and loads the
//   register defaults (3 hold ticks, 12000 rpm redline).
// Stall: a result waits in the output register while m_tready is low; the
//   next word is worked on and held at the commit step until the slot frees.
module sequential_gear_shift_controller_core
	import sgsc_pkg::*;
#(
	parameter int HOLD_COUNT_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// wheel_speed[13:0], up_pressed[14], down_pressed[15], clutch_pressed[16],
	// motor_speed[30:17], engine_speed[44:31], zero fill [47:45]
	input  logic [IN_W-1:0]       s_tdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// gear_now[2:0], solenoid_up[3], solenoid_down[4], shift_status[7:5]
	output logic [OUT_W-1:0]      m_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	sgsc_cmd_t  cmd;
	sgsc_stat_t stat;

	// result word fields seen by the checks
	logic [GEAR_W-1:0] res_gear;
	logic              res_sol_up, res_sol_dn;
	logic              res_start;

	assign cfg_ready = 1'b1;

	// control sequencer
	sgsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// arithmetic and shift state
	sgsc_datapath #(
		.HOLD_COUNT_BITS (HOLD_COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_word  (m_tdata)
	);

	assign res_gear   = m_tdata[2:0];
	assign res_sol_up = m_tdata[3];
	assign res_sol_dn = m_tdata[4];
	assign res_start  = m_tvalid && (m_tdata[7:5] == SS_START);

	// checks
	`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_sol_excl, m_tvalid, !(res_sol_up && res_sol_dn), "both solenoids on")
	`ASSERT_NEXT(a_no_quick_commit, s_tvalid && s_tready, !cmd.commit, "commit after accept")
	`ASSERT_IMPLIES(a_gear_code, m_tvalid, res_gear != 3'd7, "invalid gear code")
	`ASSERT_IMPLIES(a_start_shifting, res_start, res_gear == GEAR_SHIFTING, "start without shift")

endmodule

/* bench/sequential_gear_shift_controller_core_tb.sv */
// self-checking testbench for the sequential gear shift controller core
module sequential_gear_shift_controller_core_tb
	import sgsc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_BITS   = 8;
	localparam int HOLD_MAX    = (1 << HOLD_BITS) - 1;
	localparam int TAIL_OPS    = 40;
	localparam int SETTLE_CYC  = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_PRINTS  = 40;

	// overall ratio per gear in q0.16
	localparam longint RATIO_Q16 [0:5] = '{0, 8753, 10773, 13082, 15745, 18099};

	// one control tick, laid out as on s_tdata from the msb down
	typedef struct packed {
		logic [SPD_W-1:0] engine;
		logic [SPD_W-1:0] motor;
		logic             clutch;
		logic             down;
		logic             up;
		logic [SPD_W-1:0] wheel;
	} tick_t;

	// one result word, laid out as on m_tdata from the msb down
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                sol_down;
		logic                sol_up;
		logic [GEAR_W-1:0]   gear;
	} shift_result_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_WRITE,
		OP_SETTLE
	} plan_kind_t;

	typedef struct {
		plan_kind_t              kind;
		tick_t                   tick;
		logic [CFG_IDX_W-1:0]    reg_idx;
		logic [CFG_DATA_W-1:0]   reg_val;
	} plan_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [IN_W-1:0] s_tdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [OUT_W-1:0] m_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_HOLD_TICKS;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	plan_op_t tick_plan[$];
	shift_result_t shift_results_due[$];
	plan_op_t op;
	logic plan_done = 1'b0;
	logic quiet_end = 1'b0;
	int ticks_in = 0;
	int ticks_out = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int send_calm = 0;
	int stall_left = 0;
	int rx_calm = 0;

	// predicted controller state and registers
	logic [GEAR_W-1:0]    pr_gear;
	logic [GEAR_W-1:0]    pr_target;
	logic [HOLD_BITS-1:0] pr_hold;
	logic                 pr_sol_up;
	logic                 pr_sol_down;
	logic [TICKS_W-1:0]   pr_hold_ticks;
	logic [RED_W-1:0]     pr_redline;

	sequential_gear_shift_controller_core #(
		.HOLD_COUNT_BITS(HOLD_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// band search on motor/engine, lowest matching gear wins
	function automatic logic [GEAR_W-1:0] band_gear(input logic [SPD_W-1:0] motor,
		input logic [SPD_W-1:0] engine);
		longint scaled;
		logic [GEAR_W-1:0] found;
		found = GEAR_SHIFTING;
		scaled = longint'(motor) << 16;
		if (engine != 0) begin
			for (int k = 5; k >= 1; k--) begin
				if (scaled <= (RATIO_Q16[k] + longint'(BAND_Q16)) * longint'(engine) &&
					scaled >= (RATIO_Q16[k] - longint'(BAND_Q16)) * longint'(engine))
					found = GEAR_W'(k);
			end
		end
		return found;
	endfunction

	// engine speed in the target gear stays under the capped redline
	function automatic logic under_redline(input logic [GEAR_W-1:0] target,
		input logic [SPD_W-1:0] wheel);
		longint red;
		red = (pr_redline > REDLINE_CAP) ? longint'(REDLINE_CAP) : longint'(pr_redline);
		if (target < GEAR_FIRST || target > GEAR_TOP)
			return 1'b0;
		return (longint'(wheel) << 16) < red * RATIO_Q16[target];
	endfunction

	// advance the predicted state by one tick and give its result word
	function automatic shift_result_t predict_shift(input tick_t t);
		shift_result_t r;
		logic [GEAR_W-1:0] g;
		logic [GEAR_W-1:0] next_gear;
		shift_status_t st;
		g = pr_gear;
		st = SS_IDLE;
		if (t.clutch && g != GEAR_SHIFTING)
			g = band_gear(t.motor, t.engine);
		if (g == GEAR_SHIFTING) begin
			if (pr_hold < HOLD_MAX)
				pr_hold = pr_hold + 1'b1;
			if (pr_hold >= pr_hold_ticks) begin
				pr_sol_up = 1'b0;
				pr_sol_down = 1'b0;
				g = pr_target;
				st = SS_DONE;
			end
		end else if (g <= GEAR_TOP) begin
			if (t.up && t.down) begin
				st = SS_BOTH;
			end else if (t.down) begin
				next_gear = (g == GEAR_NEUTRAL) ? GEAR_FIRST : GEAR_W'(g - 1);
				if (g != GEAR_FIRST && t.clutch && under_redline(next_gear, t.wheel)) begin
					pr_hold = '0;
					pr_sol_down = 1'b1;
					pr_target = next_gear;
					g = GEAR_SHIFTING;
					st = SS_START;
				end else begin
					st = SS_REFUSED;
				end
			end else if (t.up) begin
				next_gear = (g == GEAR_NEUTRAL) ? GEAR_SECOND : GEAR_W'(g + 1);
				if (g != GEAR_TOP && t.clutch &&
					(g == GEAR_NEUTRAL || under_redline(next_gear, t.wheel))) begin
					pr_hold = '0;
					pr_sol_up = 1'b1;
					pr_target = next_gear;
					g = GEAR_SHIFTING;
					st = SS_START;
				end else begin
					st = SS_REFUSED;
				end
			end
		end
		pr_gear = g;
		r.gear = g;
		r.sol_up = pr_sol_up;
		r.sol_down = pr_sol_down;
		r.status = st;
		return r;
	endfunction

	// plan building
	function automatic void add_tick(input int wheel, input bit up, input bit down,
		input bit clutch, input int motor, input int engine);
		plan_op_t p;
		p.kind = OP_TICK;
		p.tick.wheel = SPD_W'(wheel);
		p.tick.up = up;
		p.tick.down = down;
		p.tick.clutch = clutch;
		p.tick.motor = SPD_W'(motor);
		p.tick.engine = SPD_W'(engine);
		p.reg_idx = '0;
		p.reg_val = '0;
		tick_plan.push_back(p);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input int val);
		plan_op_t p;
		p.kind = OP_WRITE;
		p.tick = '0;
		p.reg_idx = idx;
		p.reg_val = CFG_DATA_W'(val);
		tick_plan.push_back(p);
	endfunction

	function automatic void add_settle();
		plan_op_t p;
		p.kind = OP_SETTLE;
		p.tick = '0;
		p.reg_idx = '0;
		p.reg_val = '0;
		tick_plan.push_back(p);
	endfunction

	// mostly ticks that measure a real gear, usually with a button, the rest pure noise
	function automatic void add_random_ticks(input int count);
		int unsigned pick;
		int unsigned g;
		int off;
		int eng;
		longint mot;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 75) begin
				g = $urandom_range(1, 5);
				off = int'($urandom_range(0, 1200)) - 600;
				eng = $urandom_range(300, 16383);
				mot = (longint'(eng) * (RATIO_Q16[g] + longint'(off))) >> 16;
				pick = $urandom_range(0, 99);
				add_tick(($urandom_range(0, 3) != 0) ? $urandom_range(0, 3500)
					: $urandom_range(0, 16383),
					pick < 40 || (pick >= 80 && pick < 85),
					pick >= 40 && pick < 85,
					$urandom_range(0, 9) != 0, int'(mot), eng);
			end else begin
				add_tick($urandom_range(0, 16383), $urandom_range(0, 1), $urandom_range(0, 1),
					$urandom_range(0, 1), $urandom_range(0, 16383),
					($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 16383));
			end
		end
	endfunction

	// one line per mismatch, printing capped
	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("mismatch at result %0d: %s got %0d want %0d", ticks_out, what, got, want);
	endtask

	// driver: words, register writes and settle points from the plan
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= CFG_HOLD_TICKS;
			cfg_data <= '0;
			plan_done <= 1'b0;
			quiet_end <= 1'b0;
		end else if ((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready)) begin
			// word or write still waiting for its handshake
		end else if (send_gap > 0) begin
			send_gap--;
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
		end else if (tick_plan.size() == 0) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
			plan_done <= 1'b1;
		end else begin
			op = tick_plan[0];
			if (op.kind == OP_TICK) begin
				s_tdata <= IN_W'(op.tick);
				s_tvalid <= 1'b1;
				cfg_valid <= 1'b0;
				void'(tick_plan.pop_front());
				// sender idle bursts with calm stretches in between
				if (!quiet_end) begin
					if (send_calm > 0) begin
						send_calm--;
					end else if ($urandom_range(0, 99) < 20) begin
						send_gap = $urandom_range(1, 13);
					end else if ($urandom_range(0, 99) < 8) begin
						send_calm = $urandom_range(10, 40);
					end
				end
			end else begin
				// writes and settle points only once every result is back
				s_tvalid <= 1'b0;
				if (!s_tvalid && !cfg_valid && ticks_in == ticks_out) begin
					cfg_valid <= (op.kind == OP_WRITE);
					cfg_index <= op.reg_idx;
					cfg_data <= op.reg_val;
					void'(tick_plan.pop_front());
				end else begin
					cfg_valid <= 1'b0;
				end
			end
			quiet_end <= (tick_plan.size() < TAIL_OPS);
		end
	end

	// receiver: ready with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (rx_calm > 0 || quiet_end) begin
			if (rx_calm > 0)
				rx_calm--;
			m_tready <= 1'b1;
		end else if ($urandom_range(0, 99) < 12) begin
			stall_left = $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			if ($urandom_range(0, 99) < 4)
				rx_calm = $urandom_range(20, 60);
			m_tready <= 1'b1;
		end
	end

	// monitor: predict on every accepted word, check every result word
	always @(posedge clk or negedge arst_n) begin
		shift_result_t got;
		shift_result_t want;
		if (!arst_n) begin
			pr_gear = GEAR_NEUTRAL;
			pr_target = GEAR_NEUTRAL;
			pr_hold = '0;
			pr_sol_up = 1'b0;
			pr_sol_down = 1'b0;
			pr_hold_ticks = HOLD_TICKS_RST;
			pr_redline = REDLINE_RST;
			ticks_in <= 0;
			ticks_out <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_HOLD_TICKS)
					pr_hold_ticks = cfg_data[TICKS_W-1:0];
				else if (cfg_index == CFG_REDLINE)
					pr_redline = cfg_data[RED_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				got = shift_result_t'(m_tdata);
				if (shift_results_due.size() == 0) begin
					report_mismatch("result word with none due", int'(m_tdata), 0);
				end else begin
					want = shift_results_due.pop_front();
					if (got.gear !== want.gear)
						report_mismatch("gear_now", int'(got.gear), int'(want.gear));
					if (got.sol_up !== want.sol_up)
						report_mismatch("solenoid_up", int'(got.sol_up), int'(want.sol_up));
					if (got.sol_down !== want.sol_down)
						report_mismatch("solenoid_down", int'(got.sol_down), int'(want.sol_down));
					if (got.status !== want.status)
						report_mismatch("shift_status", int'(got.status), int'(want.status));
					ticks_out <= ticks_out + 1;
				end
			end
			if (s_tvalid && s_tready) begin
				shift_results_due.push_back(predict_shift(tick_t'(s_tdata[$bits(tick_t)-1:0])));
				ticks_in <= ticks_in + 1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[sequential_gear_shift_controller_core] ERROR");
			$finish;
		end
	end

	// stimulus plan, reset and end of run
	initial begin
		// directed ticks at reset settings
		add_tick(0, 0, 0, 0, 0, 0);                 // neutral, nothing pressed
		add_tick(100, 1, 0, 0, 0, 0);               // up without clutch
		add_tick(100, 1, 1, 0, 0, 0);               // both buttons
		add_tick(100, 0, 1, 0, 0, 0);               // down without clutch
		add_tick(0, 0, 0, 1, 5000, 0);              // engine stopped reads as shifting
		add_tick(0, 0, 0, 0, 0, 0);
		add_tick(0, 0, 0, 0, 0, 0);                 // hold runs out, back to target
		add_tick(1000, 1, 0, 1, 1635, 8192);        // upshift from third
		add_tick(0, 0, 0, 0, 0, 0);
		add_tick(0, 0, 0, 0, 0, 0);
		add_tick(0, 0, 0, 0, 0, 0);
		add_tick(0, 1, 0, 1, 2262, 8192);           // up in top gear
		add_tick(0, 0, 1, 1, 1094, 8192);           // down in first
		add_tick(1972, 1, 0, 1, 147, 1024);         // band top edge, redline just met
		add_tick(16383, 1, 1, 0, 16383, 16383);     // buttons ignored while shifting
		add_tick(16383, 1, 0, 1, 16383, 16383);
		add_tick(0, 0, 0, 0, 0, 0);
		add_tick(1973, 1, 0, 1, 147, 1024);         // redline just missed
		add_tick(0, 0, 0, 1, 148, 1024);            // just outside the first band
		add_tick(16383, 0, 1, 1, 16383, 16383);     // all fields at max
		add_tick(16383, 0, 1, 1, 1346, 8192);       // downshift refused on redline
		add_tick(0, 0, 1, 1, 1346, 8192);           // downshift to first
		add_settle();
		add_tick(0, 0, 0, 0, 0, 0);
		add_tick(0, 0, 0, 0, 0, 0);
		add_tick(0, 0, 0, 0, 0, 0);
		// short hold, top redline
		add_write(CFG_HOLD_TICKS, 1);
		add_write(CFG_REDLINE, 14000);
		add_random_ticks(70);
		// hold of zero, redline above the cap
		add_write(CFG_HOLD_TICKS, 0);
		add_write(CFG_REDLINE, 16383);
		add_random_ticks(60);
		// longest hold, zero redline
		add_write(CFG_HOLD_TICKS, 255);
		add_write(CFG_REDLINE, 0);
		add_random_ticks(40);
		// random middle settings with a settle point
		add_write(CFG_HOLD_TICKS, $urandom_range(2, 9));
		add_write(CFG_REDLINE, $urandom_range(4000, 14000));
		add_random_ticks(50);
		add_settle();
		add_random_ticks(50);
		// back near defaults for the tail
		add_write(CFG_HOLD_TICKS, 2);
		add_write(CFG_REDLINE, 12000);
		add_random_ticks(100);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (!(plan_done && ticks_in == ticks_out))
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
		if (shift_results_due.size() != 0)
			report_mismatch("results never produced", shift_results_due.size(), 0);
		if (mismatches == 0)
			$display("[sequential_gear_shift_controller_core] OK");
		else
			$display("[sequential_gear_shift_controller_core] ERROR");
		$finish;
	end

endmodule
